// File: rtl/iddt_pkg.sv
// Package: widths, command codes and difference enumeration for the DDT tracker.
package iddt_pkg;

  localparam int BITS   = 6;
  localparam int FLD_W  = 6;
  localparam int NPTS   = 1 << BITS;
  localparam int KW     = BITS - 1;
  localparam int DW     = 2 * BITS;
  localparam int NDDT   = 1 << DW;
  localparam int CW     = 3;
  localparam logic [CW-1:0] CMAX = CW'(7);
  localparam logic [CW-1:0] CPAIR = CW'(1);
  localparam logic [KW-1:0] KFIRST = KW'(1);
  localparam logic [KW-1:0] KLAST = KW'(NPTS / 2 - 1);

  typedef enum logic [0:0] {
    CMD_PLACE  = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  // k-th nonzero even-weight difference in increasing order: k with its parity appended
  function automatic logic [BITS-1:0] diff_of(input logic [KW-1:0] k);
    diff_of = {k, ^k};
  endfunction

endpackage

// File: rtl/incremental_ddt_apn_tracker.sv
// Top level: incremental partial-S-box DDT tracker with APN check.
//
// After reset the block sweeps the 4096-entry DDT memory to zero, one entry
// per cycle, and holds busy_o high for the whole sweep. A command is taken
// when start_i is high and busy_o is low. A place walks the 31 nonzero
// even-weight differences through a three-stage pipeline (partner value read,
// DDT read, DDT write-back), one difference per cycle: busy_o stays high until
// the walk is done, and the walk stops early when an entry exceeds one pair.
// A remove first fetches the point's own value in a load state; a remove of an
// undefined point answers in the next cycle without raising busy_o. The
// result is a single-cycle done_o beat with still_apn_o and cannot be stalled.
module incremental_ddt_apn_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        cmd_i,
  input  logic [iddt_pkg::FLD_W-1:0]  position_i,
  input  logic [iddt_pkg::FLD_W-1:0]  value_i,
  output logic                        done_o,
  output logic                        still_apn_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_WALK
  } state_e;

  state_e                          state_q;
  logic                            cmd_q;
  logic [iddt_pkg::BITS-1:0]       pos_q;
  logic [iddt_pkg::BITS-1:0]       own_q;
  logic [iddt_pkg::KW-1:0]         k_q;
  logic                            issue_q;
  logic                            s1_v_q, s1_def_q, s1_last_q;
  logic [iddt_pkg::BITS-1:0]       s1_a_q;
  logic                            s2_v_q, s2_def_q, s2_last_q;
  logic [iddt_pkg::DW-1:0]         s2_idx_q;
  logic [iddt_pkg::NPTS-1:0]       defined_q;
  logic [iddt_pkg::DW-1:0]         clr_q;
  logic                            done_q, apn_q;

  logic [iddt_pkg::BITS-1:0]       mv_mem [iddt_pkg::NPTS];
  logic [iddt_pkg::BITS-1:0]       mv_rd_q;
  logic [iddt_pkg::CW-1:0]         ddt_mem [iddt_pkg::NDDT];
  logic [iddt_pkg::CW-1:0]         ddt_rd_q;

  logic                            accept;
  logic [iddt_pkg::BITS-1:0]       pos_in, val_in;
  logic [iddt_pkg::BITS-1:0]       a_cur, partner, mv_raddr;
  logic [iddt_pkg::DW-1:0]         ddt_raddr, ddt_waddr;
  logic [iddt_pkg::CW-1:0]         cnt_new, ddt_wdata;
  logic                            is_place, act, stop, fin, ddt_we;

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign pos_in      = iddt_pkg::BITS'(position_i);
  assign val_in      = iddt_pkg::BITS'(value_i);
  assign done_o      = done_q;
  assign still_apn_o = apn_q;

  assign a_cur     = iddt_pkg::diff_of(k_q);
  assign partner   = pos_q ^ a_cur;
  assign mv_raddr  = (state_q == ST_WALK) ? partner : pos_in;
  assign ddt_raddr = {s1_a_q, own_q ^ mv_rd_q};

  assign is_place = (cmd_q == iddt_pkg::CMD_PLACE);

  always_comb begin
    if (is_place) begin
      cnt_new = (ddt_rd_q == iddt_pkg::CMAX) ? ddt_rd_q : ddt_rd_q + iddt_pkg::CW'(1);
    end else begin
      cnt_new = (ddt_rd_q == '0) ? ddt_rd_q : ddt_rd_q - iddt_pkg::CW'(1);
    end
  end

  assign act  = (state_q == ST_WALK) && s2_v_q && s2_def_q;
  assign stop = act && (is_place ? (cnt_new > iddt_pkg::CPAIR) : (cnt_new == iddt_pkg::CPAIR));
  assign fin  = (state_q == ST_WALK) && s2_v_q && (stop || s2_last_q);

  assign ddt_we    = (state_q == ST_CLEAR) || act;
  assign ddt_waddr = (state_q == ST_CLEAR) ? clr_q : s2_idx_q;
  assign ddt_wdata = (state_q == ST_CLEAR) ? '0 : cnt_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      defined_q <= '0;
      issue_q   <= 1'b0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      done_q    <= 1'b0;
      apn_q     <= 1'b0;
      cmd_q     <= 1'b0;
      pos_q     <= '0;
      own_q     <= '0;
      k_q       <= '0;
      s1_def_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s1_a_q    <= '0;
      s2_def_q  <= 1'b0;
      s2_last_q <= 1'b0;
      s2_idx_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + iddt_pkg::DW'(1);
          if (clr_q == iddt_pkg::DW'(iddt_pkg::NDDT - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_q <= cmd_i;
            pos_q <= pos_in;
            own_q <= val_in;
            k_q   <= iddt_pkg::KFIRST;
            if (cmd_i == iddt_pkg::CMD_PLACE) begin
              defined_q[pos_in] <= 1'b1;
              issue_q           <= 1'b1;
              state_q           <= ST_WALK;
            end else if (defined_q[pos_in]) begin
              state_q <= ST_LOAD;
            end else begin
              done_q <= 1'b1;
              apn_q  <= 1'b1;
            end
          end
        end
        ST_LOAD: begin
          own_q   <= mv_rd_q;
          issue_q <= 1'b1;
          state_q <= ST_WALK;
        end
        ST_WALK: begin
          s1_v_q    <= issue_q && !fin;
          s1_def_q  <= defined_q[partner];
          s1_last_q <= (k_q == iddt_pkg::KLAST);
          s1_a_q    <= a_cur;
          s2_v_q    <= s1_v_q && !fin;
          s2_def_q  <= s1_def_q;
          s2_last_q <= s1_last_q;
          s2_idx_q  <= ddt_raddr;
          k_q       <= k_q + iddt_pkg::KW'(1);
          if (k_q == iddt_pkg::KLAST || fin) begin
            issue_q <= 1'b0;
          end
          if (fin) begin
            done_q  <= 1'b1;
            apn_q   <= is_place ? !stop : 1'b1;
            state_q <= ST_IDLE;
            s1_v_q  <= 1'b0;
            s2_v_q  <= 1'b0;
            if (!is_place) begin
              defined_q[pos_q] <= 1'b0;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // point value memory: write on place, one registered read
  always_ff @(posedge clk_i) begin
    if (accept && (cmd_i == iddt_pkg::CMD_PLACE)) begin
      mv_mem[pos_in] <= val_in;
    end
    mv_rd_q <= mv_mem[mv_raddr];
  end

  // DDT memory: rows differ per difference, so a walk never reads a row in write-back
  always_ff @(posedge clk_i) begin
    if (ddt_we) begin
      ddt_mem[ddt_waddr] <= ddt_wdata;
    end
    ddt_rd_q <= ddt_mem[ddt_raddr];
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result beat while busy");

  a_accept_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o || done_o)) else $error("accepted command neither busy nor answered");

  a_remove_apn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (cmd_q == iddt_pkg::CMD_REMOVE)) |-> still_apn_o)
    else $error("remove reported not APN");

  a_remove_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (cmd_q == iddt_pkg::CMD_REMOVE)) |-> !defined_q[pos_q])
    else $error("removed point still defined");

  a_place_def: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (cmd_q == iddt_pkg::CMD_PLACE)) |-> defined_q[pos_q])
    else $error("placed point not defined");

endmodule
